@@ rtl/i8080af_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080af_pkg
// shared types and codes of the 8080/8085 alu and flag block
// ----------------------------------------------------------------------------
package i8080af_pkg;

    localparam int OPCODE_W = 5;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_ADD  = 5'd0;
    localparam logic [OPCODE_W-1:0] OP_ADC  = 5'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB  = 5'd2;
    localparam logic [OPCODE_W-1:0] OP_SBB  = 5'd3;
    localparam logic [OPCODE_W-1:0] OP_ANA  = 5'd4;
    localparam logic [OPCODE_W-1:0] OP_XRA  = 5'd5;
    localparam logic [OPCODE_W-1:0] OP_ORA  = 5'd6;
    localparam logic [OPCODE_W-1:0] OP_CMP  = 5'd7;
    localparam logic [OPCODE_W-1:0] OP_INR  = 5'd8;
    localparam logic [OPCODE_W-1:0] OP_DCR  = 5'd9;
    localparam logic [OPCODE_W-1:0] OP_RLC  = 5'd10;
    localparam logic [OPCODE_W-1:0] OP_RRC  = 5'd11;
    localparam logic [OPCODE_W-1:0] OP_RAL  = 5'd12;
    localparam logic [OPCODE_W-1:0] OP_RAR  = 5'd13;
    localparam logic [OPCODE_W-1:0] OP_CMA  = 5'd14;
    localparam logic [OPCODE_W-1:0] OP_STC  = 5'd15;
    localparam logic [OPCODE_W-1:0] OP_CMC  = 5'd16;
    localparam logic [OPCODE_W-1:0] OP_DAD  = 5'd17;
    localparam logic [OPCODE_W-1:0] OP_DSUB = 5'd18;
    localparam logic [OPCODE_W-1:0] OP_ASRH = 5'd19;
    localparam logic [OPCODE_W-1:0] OP_RLDE = 5'd20;
    localparam logic [OPCODE_W-1:0] OP_INX  = 5'd21;
    localparam logic [OPCODE_W-1:0] OP_DCX  = 5'd22;

    // flag bit positions
    localparam int FB_C = 0;
    localparam int FB_N = 1;
    localparam int FB_V = 2;
    localparam int FB_X = 3;
    localparam int FB_H = 4;
    localparam int FB_Z = 6;
    localparam int FB_S = 7;

    // register index of cpu_variant
    localparam logic REG_CPU_VARIANT = 1'b0;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   accumulator;
        logic [WORD_W-1:0]   operand;
        logic [WORD_W-1:0]   hl_pair;
        logic [BYTE_W-1:0]   flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic [BYTE_W-1:0] flags_out;
    } alu_rsp_t;

endpackage

@@ rtl/i8080af_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080af_in_if
// operation channel: valid/ready with one alu request per transaction
// ----------------------------------------------------------------------------
interface i8080af_in_if import i8080af_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   accumulator;
    logic [WORD_W-1:0]   operand;
    logic [WORD_W-1:0]   hl_pair;
    logic [BYTE_W-1:0]   flags_in;

    modport source (output valid, opcode, accumulator, operand, hl_pair, flags_in,
                    input ready);
    modport sink   (input valid, opcode, accumulator, operand, hl_pair, flags_in,
                    output ready);
endinterface

@@ rtl/i8080af_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080af_out_if
// result channel: valid/ready with one result and flag byte per transaction
// ----------------------------------------------------------------------------
interface i8080af_out_if import i8080af_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] result;
    logic [BYTE_W-1:0] flags_out;

    modport source (output valid, result, flags_out, input ready);
    modport sink   (input valid, result, flags_out, output ready);
endinterface

@@ rtl/i8080_alu_flags_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080_alu_flags_core
// 8080/8085 alu with flag logic behind valid/ready channels and an apb port
// ----------------------------------------------------------------------------
// One operation per transaction on in_ch gives one result and flag byte per
// transaction on out_ch. The block sustains one transaction per cycle while
// out_ch is not stalled: every operation goes through a single pass of the
// alu, which sits between the input register and the result register, so an
// accepted operation is offered on out_ch once the result register holds it.
// A stalled result is held in the result register while one more operation
// waits in the input register; in_ch.ready drops only when both are full.
// The cpu_variant register (apb byte addresses 0 to 3, bit 0) picks 8080 (0)
// or 8085 (1) behaviour; it should only be written while no transaction is
// in flight. Reads of byte addresses 4 to 7 return zero and writes there are
// ignored.
// ----------------------------------------------------------------------------
module i8080_alu_flags_core import i8080af_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    i8080af_in_if.sink        in_ch,
    i8080af_out_if.source     out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // configuration register
    logic cpu_variant_reg;
    logic cpu_variant_next;
    logic cfg_write;
    logic cfg_hit;

    // input register stage
    logic     s1_valid_reg;
    logic     s1_valid_next;
    alu_req_t s1_req_reg;

    // result register stage
    logic     s2_valid_reg;
    logic     s2_valid_next;
    alu_rsp_t s2_rsp_reg;
    alu_rsp_t alu_rsp;

    logic s2_take;
    logic in_ready;

    // ------------------------------------------------------------------
    // apb port: word index sits above the byte offset bits
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[APB_AW-1] == REG_CPU_VARIANT);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

    always_comb
    begin
        cpu_variant_next = cpu_variant_reg;
        if (cfg_write)
        begin
            cpu_variant_next = pwdata[0];
        end
    end

    assign prdata = cfg_hit ? {{(APB_DW-1){1'b0}}, cpu_variant_reg} : '0;

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    // the result register frees up when empty or being drained this cycle
    assign s2_take  = !s2_valid_reg || out_ch.ready;
    // the input register can load when empty or moving on to the result
    assign in_ready = !s1_valid_reg || s2_take;

    assign in_ch.ready = in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_ch.valid;
        end
        if (s2_take)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_variant_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end
        else
        begin
            cpu_variant_reg <= cpu_variant_next;
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_ch.valid)
        begin
            s1_req_reg.opcode      <= in_ch.opcode;
            s1_req_reg.accumulator <= in_ch.accumulator;
            s1_req_reg.operand     <= in_ch.operand;
            s1_req_reg.hl_pair     <= in_ch.hl_pair;
            s1_req_reg.flags_in    <= in_ch.flags_in;
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_rsp_reg <= alu_rsp;
        end
    end

    // ------------------------------------------------------------------
    // alu datapath
    // ------------------------------------------------------------------
    i8080af_alu u_alu
    (
        .req  (s1_req_reg),
        .is85 (cpu_variant_reg),
        .rsp  (alu_rsp)
    );

    // ------------------------------------------------------------------
    // result channel
    // ------------------------------------------------------------------
    assign out_ch.valid     = s2_valid_reg;
    assign out_ch.result    = s2_rsp_reg.result;
    assign out_ch.flags_out = s2_rsp_reg.flags_out;

endmodule

@@ rtl/i8080af_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080af_alu
// single-pass alu datapath with 8080/8085 flag logic
// ----------------------------------------------------------------------------
module i8080af_alu import i8080af_pkg::*;
(
    input  alu_req_t req,
    input  logic     is85,
    output alu_rsp_t rsp
);

    typedef struct packed {
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] value;
    } byte_res_t;

    function automatic logic [BYTE_W-1:0] zs_of(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] f;
        f       = '0;
        f[FB_S] = x[7];
        f[FB_Z] = (x == '0);
        return f;
    endfunction

    function automatic logic [BYTE_W-1:0] zsp_of(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] f;
        f       = zs_of(x);
        f[FB_V] = ~(^x);
        return f;
    endfunction

    function automatic byte_res_t add8(input logic [BYTE_W-1:0] a,
                                       input logic [BYTE_W-1:0] v,
                                       input logic              c);
        logic [BYTE_W:0] q;
        byte_res_t       res;
        q             = {1'b0, a} + {1'b0, v} + {{BYTE_W{1'b0}}, c};
        res.value     = q[BYTE_W-1:0];
        res.flags     = zsp_of(q[BYTE_W-1:0]);
        res.flags[FB_C] = q[BYTE_W];
        res.flags[FB_H] = a[4] ^ q[4] ^ v[4];
        // overflow shares the parity bit
        res.flags[FB_V] = res.flags[FB_V] | (~(a[7] ^ v[7]) & (v[7] ^ q[7]));
        return res;
    endfunction

    function automatic byte_res_t sub8(input logic [BYTE_W-1:0] a,
                                       input logic [BYTE_W-1:0] v,
                                       input logic              c,
                                       input logic              zp);
        logic [BYTE_W:0] q;
        byte_res_t       res;
        q             = {1'b0, a} - {1'b0, v} - {{BYTE_W{1'b0}}, c};
        res.value     = q[BYTE_W-1:0];
        res.flags     = zp ? zsp_of(q[BYTE_W-1:0]) : zs_of(q[BYTE_W-1:0]);
        res.flags[FB_C] = q[BYTE_W];
        res.flags[FB_N] = 1'b1;
        res.flags[FB_H] = a[4] ^ q[4] ^ v[4];
        res.flags[FB_V] = res.flags[FB_V] | ((v[7] ^ a[7]) & (a[7] ^ q[7]));
        return res;
    endfunction

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] v;
    logic [BYTE_W-1:0] f;
    logic              c;
    logic [WORD_W-1:0] pr;
    logic [WORD_W-1:0] hl;
    byte_res_t         br;
    byte_res_t         br_hi;
    logic [WORD_W:0]   dad_sum;
    logic [WORD_W-1:0] word_res;

    assign a  = req.accumulator;
    assign v  = req.operand[BYTE_W-1:0];
    assign f  = req.flags_in;
    assign c  = req.flags_in[FB_C];
    assign pr = req.operand;
    assign hl = req.hl_pair;

    always_comb
    begin
        rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, a};
        rsp.flags_out = f;
        br            = '0;
        br_hi         = '0;
        dad_sum       = '0;
        word_res      = '0;
        case (req.opcode)
            OP_ADD, OP_ADC:
            begin
                br = add8(a, v, (req.opcode == OP_ADC) ? c : 1'b0);
                rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, br.value};
                rsp.flags_out = br.flags;
            end
            OP_SUB, OP_SBB:
            begin
                br = sub8(a, v, (req.opcode == OP_SBB) ? c : 1'b0, 1'b1);
                rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, br.value};
                rsp.flags_out = br.flags;
            end
            OP_CMP:
            begin
                br = sub8(a, v, 1'b0, 1'b1);
                rsp.flags_out = br.flags;
            end
            OP_ANA:
            begin
                br.value      = a & v;
                rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, br.value};
                rsp.flags_out = zsp_of(br.value);
                // 8080 half-carry comes from bit 3 of the or of the operands
                rsp.flags_out[FB_H] = is85 | a[3] | v[3];
            end
            OP_XRA:
            begin
                br.value      = a ^ v;
                rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, br.value};
                rsp.flags_out = zsp_of(br.value);
            end
            OP_ORA:
            begin
                br.value      = a | v;
                rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, br.value};
                rsp.flags_out = zsp_of(br.value);
            end
            OP_INR:
            begin
                br.value      = v + 8'd1;
                rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, br.value};
                rsp.flags_out = zsp_of(br.value);
                rsp.flags_out[FB_C] = c;
                rsp.flags_out[FB_H] = (v[3:0] == 4'hf);
            end
            OP_DCR:
            begin
                br.value      = v - 8'd1;
                rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, br.value};
                rsp.flags_out = zsp_of(br.value);
                rsp.flags_out[FB_C] = c;
                rsp.flags_out[FB_H] = (v[3:0] == 4'h0);
                rsp.flags_out[FB_N] = 1'b1;
            end
            OP_RLC:
            begin
                rsp.result = {{(WORD_W-BYTE_W){1'b0}}, a[6:0], a[7]};
                rsp.flags_out[FB_C] = a[7];
            end
            OP_RRC:
            begin
                rsp.result = {{(WORD_W-BYTE_W){1'b0}}, a[0], a[7:1]};
                rsp.flags_out[FB_C] = a[0];
            end
            OP_RAL:
            begin
                rsp.result = {{(WORD_W-BYTE_W){1'b0}}, a[6:0], c};
                rsp.flags_out[FB_C] = a[7];
            end
            OP_RAR:
            begin
                rsp.result = {{(WORD_W-BYTE_W){1'b0}}, c, a[7:1]};
                rsp.flags_out[FB_C] = a[0];
            end
            OP_CMA:
            begin
                rsp.result = {{(WORD_W-BYTE_W){1'b0}}, ~a};
                if (is85)
                begin
                    rsp.flags_out[FB_H] = 1'b1;
                    rsp.flags_out[FB_N] = 1'b1;
                end
            end
            OP_STC:
            begin
                rsp.flags_out[FB_C] = 1'b1;
            end
            OP_CMC:
            begin
                rsp.flags_out[FB_C] = ~c;
            end
            OP_DAD:
            begin
                dad_sum    = {1'b0, hl} + {1'b0, pr};
                rsp.result = dad_sum[WORD_W-1:0];
                rsp.flags_out[FB_H] = hl[12] ^ pr[12] ^ dad_sum[12];
                rsp.flags_out[FB_C] = dad_sum[WORD_W];
            end
            OP_DSUB:
            begin
                rsp.result = hl;
                if (is85)
                begin
                    br    = sub8(hl[BYTE_W-1:0], pr[BYTE_W-1:0], 1'b0, 1'b0);
                    br_hi = sub8(hl[WORD_W-1:BYTE_W], pr[WORD_W-1:BYTE_W],
                                 br.flags[FB_C], 1'b0);
                    rsp.result    = {br_hi.value, br.value};
                    rsp.flags_out = br_hi.flags;
                    // zero only when the whole word is zero
                    if (br.value != '0)
                    begin
                        rsp.flags_out[FB_Z] = 1'b0;
                    end
                end
            end
            OP_ASRH:
            begin
                rsp.result = hl;
                if (is85)
                begin
                    rsp.result = {hl[WORD_W-1], hl[WORD_W-1:1]};
                    rsp.flags_out[FB_C] = hl[0];
                end
            end
            OP_RLDE:
            begin
                rsp.result = pr;
                if (is85)
                begin
                    rsp.result = {pr[WORD_W-2:0], pr[WORD_W-1]};
                    rsp.flags_out[FB_C] = pr[WORD_W-1];
                    rsp.flags_out[FB_V] = pr[WORD_W-1] ^ pr[WORD_W-2];
                end
            end
            OP_INX:
            begin
                word_res   = pr + 16'd1;
                rsp.result = word_res;
                if (is85)
                begin
                    rsp.flags_out[FB_X] = (word_res[BYTE_W-1:0] == 8'h00);
                end
            end
            OP_DCX:
            begin
                word_res   = pr - 16'd1;
                rsp.result = word_res;
                if (is85)
                begin
                    rsp.flags_out[FB_X] = (word_res[BYTE_W-1:0] == 8'hff);
                end
            end
            default:
            begin
                rsp.result    = {{(WORD_W-BYTE_W){1'b0}}, a};
                rsp.flags_out = f;
            end
        endcase
    end

endmodule

@@ rtl/i8080af_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080af_checker
// port-level checks of the alu core, bound to the top level
// ----------------------------------------------------------------------------
module i8080af_checker import i8080af_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [WORD_W-1:0] out_result,
    input logic [BYTE_W-1:0] out_flags,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_result) && $stable(out_flags))
    else $error("result payload changed while stalled");

    // the input side only stalls when a result is waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no pending result");

    // a variant write reads back on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[APB_AW-1] == REG_CPU_VARIANT)
        |=> !(psel && !pwrite && (paddr[APB_AW-1] == REG_CPU_VARIANT))
            || (prdata[0] == $past(pwdata[0])))
    else $error("variant readback mismatch");

    // reads never show bits outside the variant register
    assert property (@(posedge clk) disable iff (!rst_n)
        prdata[APB_DW-1:1] == '0 && (!in_valid || in_valid))
    else $error("stray read data bits");

endmodule

bind i8080_alu_flags_core i8080af_checker u_i8080af_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.result),
    .out_flags  (out_ch.flags_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
);
